// File: src/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg: shared widths and codes for the wildcard byte signature scanner
// Holds the fixed field widths and the configuration register indexes.
// ----------------------------------------------------------------------------
package wbps_pkg;

    // Field widths fixed by the beat formats
    localparam int DATA_W   = 8;
    localparam int ADDR_W   = 48;
    localparam int CFG_W    = 64;
    localparam int MASK_W   = 16;
    localparam int LEN_W    = 5;
    localparam int SIG_MAX  = 16;
    localparam int SIG_IDX_W = 4;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 2'd0,
        REG_PATTERN_HIGH = 2'd1,
        REG_WILDCARD     = 2'd2,
        REG_LENGTH       = 2'd3
    } cfg_reg_t;

endpackage

// File: src/wbps_if.sv
// ----------------------------------------------------------------------------
// wbps stream interfaces
// Valid/ready channels for the scanned bytes and for the scan results.
// ----------------------------------------------------------------------------
interface wbps_byte_if;
    logic                        valid;
    logic                        ready;
    logic [wbps_pkg::DATA_W-1:0] data_byte;
    logic [wbps_pkg::ADDR_W-1:0] byte_address;
    logic                        first_of_range;
    logic                        end_of_range;

    modport source (
        output valid, data_byte, byte_address, first_of_range, end_of_range,
        input  ready
    );
    modport sink (
        input  valid, data_byte, byte_address, first_of_range, end_of_range,
        output ready
    );
endinterface

interface wbps_result_if;
    logic                        valid;
    logic                        ready;
    logic                        match_found;
    logic [wbps_pkg::ADDR_W-1:0] match_address;
    logic                        scan_done;

    modport source (
        output valid, match_found, match_address, scan_done,
        input  ready
    );
    modport sink (
        input  valid, match_found, match_address, scan_done,
        output ready
    );
endinterface

// File: src/wildcard_byte_pattern_search_unit.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search_unit: wildcard byte signature scanner
// Slides a window over a byte stream and holds the start address of the
// first window in each range that matches a signature with wildcard bytes.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Handshake      Payload
//  stream    in    valid/ready    data_byte, byte_address, first_of_range,
//                                 end_of_range
//  result    out   valid/ready    match_found, match_address, scan_done
//  cfg       in    cfg_write      cfg_index, cfg_data (no read-back)
//
//  One beat per cycle sustained while the result is not stalled; a taken byte
//  passes the input register, then the result register.
//  The window compare, length select and start-address subtract sit between
//  the input register and the result register.
//  Reset clears the window, the range state and the configuration registers.
//  A stalled result holds the result register; the input register keeps
//  taking beats until it too is full.
//
module wildcard_byte_pattern_search_unit #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [wbps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wbps_pkg::CFG_W-1:0]     cfg_data,
    wbps_byte_if.sink                      stream,
    wbps_result_if.source                  result
);
    import wbps_pkg::*;

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);

    // Configuration registers
    logic [CFG_W-1:0]  pat_low_reg;
    logic [CFG_W-1:0]  pat_high_reg;
    logic [MASK_W-1:0] wild_reg;
    logic [LEN_W-1:0]  len_reg;

    // Input register
    logic              in_valid_reg;
    logic [DATA_W-1:0] in_data_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    logic              in_first_reg;
    logic              in_last_reg;

    // Scan state
    logic [DATA_W-1:0] window_reg [MAX_PATTERN];
    logic [DATA_W-1:0] window_next [MAX_PATTERN];
    logic [CNT_W-1:0]  seen_reg;
    logic [CNT_W-1:0]  seen_next;
    logic              held_reg;
    logic              held_next;
    logic [ADDR_W-1:0] held_addr_reg;
    logic [ADDR_W-1:0] held_addr_next;

    // Result register
    logic              out_valid_reg;
    logic              out_found_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic              out_done_reg;

    logic              out_free;
    logic              advance;
    logic              take;
    logic [DATA_W-1:0] sig [SIG_MAX];
    logic [LEN_W-1:0]  eff_len;
    logic              window_hit;
    cfg_reg_t          cfg_sel;

    assign cfg_sel = cfg_reg_t'(cfg_index);

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            wild_reg     <= '0;
            len_reg      <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_PATTERN_LOW:  pat_low_reg  <= cfg_data;
                REG_PATTERN_HIGH: pat_high_reg <= cfg_data;
                REG_WILDCARD:     wild_reg     <= cfg_data[MASK_W-1:0];
                REG_LENGTH:       len_reg      <= cfg_data[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    // Handshake: advance when the result register is free or being drained
    assign out_free     = !out_valid_reg || result.ready;
    assign advance      = in_valid_reg && out_free;
    assign stream.ready = !in_valid_reg || out_free;
    assign take         = stream.valid && stream.ready;

    // Hold the accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            in_valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg  <= stream.data_byte;
            in_addr_reg  <= stream.byte_address;
            in_first_reg <= stream.first_of_range;
            in_last_reg  <= stream.end_of_range;
        end
    end

    // Unpack the signature bytes
    always_comb
    begin
        for (int b = 0; b < SIG_MAX / 2; b++)
        begin
            sig[b]             = pat_low_reg[b*DATA_W +: DATA_W];
            sig[b + SIG_MAX/2] = pat_high_reg[b*DATA_W +: DATA_W];
        end
    end

    // Clamp the signature length to the window depth
    assign eff_len = (len_reg > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_reg;

    // Shift the window and count bytes, starting afresh on a range start
    always_comb
    begin
        window_next[0] = in_data_reg;
        for (int k = 1; k < MAX_PATTERN; k++)
        begin
            window_next[k] = in_first_reg ? '0 : window_reg[k-1];
        end
        if (in_first_reg)
        begin
            seen_next = CNT_W'(1);
        end
        else if (seen_reg < CNT_W'(MAX_PATTERN))
        begin
            seen_next = seen_reg + 1'b1;
        end
        else
        begin
            seen_next = seen_reg;
        end
    end

    // Compare window entry j with signature byte eff_len-1-j
    always_comb
    begin
        logic [LEN_W-1:0] idx;
        logic             care;
        window_hit = 1'b1;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            idx  = LEN_W'(eff_len - LEN_W'(j) - 1'b1);
            care = (LEN_W'(j) < eff_len) && !wild_reg[idx[SIG_IDX_W-1:0]];
            if (care && (window_next[j] != sig[idx[SIG_IDX_W-1:0]]))
            begin
                window_hit = 1'b0;
            end
        end
    end

    // Latch the first match of the range
    always_comb
    begin
        held_next      = in_first_reg ? 1'b0 : held_reg;
        held_addr_next = in_first_reg ? '0 : held_addr_reg;
        if (!held_next && (eff_len != '0) && (LEN_W'(seen_next) >= eff_len) && window_hit)
        begin
            held_next      = 1'b1;
            held_addr_next = in_addr_reg - ADDR_W'(eff_len - 1'b1);
        end
    end

    // Update scan state on each advanced beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                window_reg[k] <= '0;
            end
            seen_reg      <= '0;
            held_reg      <= 1'b0;
            held_addr_reg <= '0;
        end
        else if (advance)
        begin
            window_reg    <= window_next;
            seen_reg      <= seen_next;
            held_reg      <= held_next;
            held_addr_reg <= held_addr_next;
        end
    end

    // Load the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_found_reg <= held_next;
            out_addr_reg  <= held_addr_next;
            out_done_reg  <= in_last_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.match_found   = out_found_reg;
    assign result.match_address = out_addr_reg;
    assign result.scan_done     = out_done_reg;

endmodule

// File: src/wbps_checker.sv
// ----------------------------------------------------------------------------
// wbps_checker: port-level checks for the signature scanner
// Watches the stream, result and stall relation on the top-level ports.
// ----------------------------------------------------------------------------
module wbps_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        out_found,
    input logic [wbps_pkg::ADDR_W-1:0] out_addr,
    input logic                        out_done
);
    import wbps_pkg::*;

    // A stalled result beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_found)
            && $stable(out_addr) && $stable(out_done))
        else $error("result beat changed while stalled");

    // No match means a zero address
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_found |-> out_addr == '0)
        else $error("address shown without a match");

    // Back-pressure on the stream only comes from a stalled result
    a_stall_origin: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("stream stalled without a stalled result");

    // A beat accepted while no result is held comes out through the input and result registers
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> ##1 out_valid)
        else $error("accepted beat produced no result");

endmodule

bind wildcard_byte_pattern_search_unit wbps_checker u_wbps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (stream.valid),
    .in_ready  (stream.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_found (result.match_found),
    .out_addr  (result.match_address),
    .out_done  (result.scan_done)
);
